// File: design/dmcsr_pkg.sv
package dmcsr_pkg;

    localparam logic [62:0] MOD_P = 63'h7fffffffffffffe7;
    localparam logic [62:0] MOD_Q = 63'h7fffffffffffff5b;
    localparam logic [62:0] STRIDE_P_RST = 63'h39F750241C2D5D33;
    localparam logic [62:0] STRIDE_Q_RST = 63'h32F50FEE9B2A32BB;
    localparam logic [63:0] MIX_BASE_RST = 64'hA2CB4411BA257552;
    localparam logic [63:0] TOP_BIT = 64'h8000000000000000;

    localparam logic OP_NEXT = 1'b0;
    localparam logic OP_SEEK = 1'b1;

    localparam logic [1:0] REG_STRIDE_P = 2'd0;
    localparam logic [1:0] REG_STRIDE_Q = 2'd1;
    localparam logic [1:0] REG_MIX_BASE = 2'd2;

    typedef enum logic [1:0] {
        MUL_MIX = 2'd0,
        MUL_SQR = 2'd1
    } t_mul_sel;

    typedef struct packed {
        logic     load_in;
        logic     seek_clear;
        logic     seek_step;
        logic     mul_start;
        t_mul_sel mul_sel;
        logic     mul_part;
        logic     mul_fold;
        logic     adv;
        logic     out_load;
    } t_cmd;

    typedef struct packed {
        logic mul_last;
    } t_sts;

endpackage

// File: design/dmcsr_if.sv
interface dmcsr_in_if (input logic i_clk);
    logic        valid;
    logic        ready;
    logic        op;
    logic [63:0] seek_index;
    modport source (output valid, output op, output seek_index, input ready);
    modport sink (input valid, input op, input seek_index, output ready);
endinterface

interface dmcsr_out_if (input logic i_clk);
    logic        valid;
    logic        ready;
    logic [63:0] random_word;
    modport source (output valid, output random_word, input ready);
    modport sink (input valid, input random_word, output ready);
endinterface

// File: design/dual_modular_counter_squaring_rng.sv
// Generates one 64-bit random word per next beat from two counters (mod 2^63-25 and
// 2^63-165) mixed with a base word, multiplied, then squared. Both 64x64 products share
// one 32x32 multiplier, four partial products each. A next beat holds the block through
// the accept cycle, the first product (S_MUL1, S_FIN1), the square (S_SQ, S_FIN2) and the
// load of the output register (S_OUT); a result still held stalls the following next beat
// in S_OUT until it is taken. A seek beat runs double-and-add over the index, one index
// bit per cycle, and returns nothing.
// One beat is in work at a time.
module dual_modular_counter_squaring_rng (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dmcsr_in_if.sink    in_ch,
    dmcsr_out_if.source out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    logic [62:0] r_stride_p, r_stride_q;
    logic [63:0] r_mix_base;
    dmcsr_pkg::t_cmd cmd;
    dmcsr_pkg::t_sts sts;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stride_p <= dmcsr_pkg::STRIDE_P_RST;
            r_stride_q <= dmcsr_pkg::STRIDE_Q_RST;
            r_mix_base <= dmcsr_pkg::MIX_BASE_RST;
        end else if (psel && penable && pwrite && paddr[2:0] == 3'd0) begin
            case (reg_idx)
                dmcsr_pkg::REG_STRIDE_P: r_stride_p <= pwdata[62:0];
                dmcsr_pkg::REG_STRIDE_Q: r_stride_q <= pwdata[62:0];
                dmcsr_pkg::REG_MIX_BASE: r_mix_base <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            dmcsr_pkg::REG_STRIDE_P: prdata = {1'b0, r_stride_p};
            dmcsr_pkg::REG_STRIDE_Q: prdata = {1'b0, r_stride_q};
            dmcsr_pkg::REG_MIX_BASE: prdata = r_mix_base;
            default:                 prdata = '0;
        endcase
    end

    dmcsr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_ch.valid),
        .i_in_op     (in_ch.op),
        .o_in_ready  (in_ch.ready),
        .o_out_valid (out_ch.valid),
        .i_out_ready (out_ch.ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    dmcsr_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_seek_index (in_ch.seek_index),
        .i_stride_p   (r_stride_p),
        .i_stride_q   (r_stride_q),
        .i_mix_base   (r_mix_base),
        .o_word       (out_ch.random_word)
    );

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
        else $error("beat taken while busy");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_ch.valid && !out_ch.ready) |=> out_ch.valid)
        else $error("result dropped");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(in_ch.ready && cmd.mul_part))
        else $error("multiplier active while idle");
endmodule

// File: design/dmcsr_datapath.sv
module dmcsr_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dmcsr_pkg::t_cmd   i_cmd,
    output dmcsr_pkg::t_sts   o_sts,
    input  logic [63:0]       i_seek_index,
    input  logic [62:0]       i_stride_p,
    input  logic [62:0]       i_stride_q,
    input  logic [63:0]       i_mix_base,
    output logic [63:0]       o_word
);
    logic [62:0]  r_cnt_p, r_cnt_q;
    logic [63:0]  r_idx;
    logic [63:0]  r_a, r_b;
    logic [1:0]   r_ph;
    logic [127:0] r_acc;
    logic [63:0]  r_pp;
    logic [1:0]   r_pp_ph;
    logic [63:0]  r_word;

    logic [63:0] w1, w2, mid;
    logic [31:0] ma, mb;
    logic [63:0] n_pp;
    logic [127:0] pp_sh;

    function automatic logic [62:0] add_mod(input logic [62:0] a, input logic [62:0] b,
                                            input logic [62:0] m);
        logic [63:0] s1, s2, s3;
        s1 = {1'b0, a} + {1'b0, b};
        s2 = (s1 >= {1'b0, m}) ? s1 - {1'b0, m} : s1;
        s3 = (s2 >= {1'b0, m}) ? s2 - {1'b0, m} : s2;
        return s3[62:0];
    endfunction

    function automatic logic [62:0] red(input logic [62:0] x, input logic [62:0] m);
        return (x >= m) ? x - m : x;
    endfunction

    function automatic logic [62:0] dbl_mod(input logic [62:0] x, input logic [62:0] m);
        logic [63:0] s;
        s = {x, 1'b0};
        if (s >= {1'b0, m}) s = s - {1'b0, m};
        return s[62:0];
    endfunction

    assign w1  = ({1'b0, r_cnt_p} ^ i_mix_base) | dmcsr_pkg::TOP_BIT;
    assign w2  = ({1'b0, r_cnt_q} ^ i_mix_base) | dmcsr_pkg::TOP_BIT;
    assign mid = r_acc[95:32] | dmcsr_pkg::TOP_BIT;
    assign ma  = r_ph[1] ? r_a[63:32] : r_a[31:0];
    assign mb  = r_ph[0] ? r_b[63:32] : r_b[31:0];
    assign n_pp = {32'd0, ma} * {32'd0, mb};
    assign pp_sh = {64'd0, r_pp} << (7'(r_pp_ph[1]) * 7'd32 + 7'(r_pp_ph[0]) * 7'd32);
    assign o_sts.mul_last = (r_ph == 2'd3);
    assign o_word = r_word;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_idx <= i_seek_index;
        end
        if (!i_rst_n || i_cmd.seek_clear) begin
            r_cnt_p <= '0;
            r_cnt_q <= '0;
        end else if (i_cmd.seek_step) begin
            r_cnt_p <= add_mod(dbl_mod(r_cnt_p, dmcsr_pkg::MOD_P), r_idx[63] ?
                               red(i_stride_p, dmcsr_pkg::MOD_P) : '0, dmcsr_pkg::MOD_P);
            r_cnt_q <= add_mod(dbl_mod(r_cnt_q, dmcsr_pkg::MOD_Q), r_idx[63] ?
                               red(i_stride_q, dmcsr_pkg::MOD_Q) : '0, dmcsr_pkg::MOD_Q);
            r_idx <= {r_idx[62:0], 1'b0};
        end else if (i_cmd.adv) begin
            r_cnt_p <= add_mod(r_cnt_p, i_stride_p, dmcsr_pkg::MOD_P);
            r_cnt_q <= add_mod(r_cnt_q, i_stride_q, dmcsr_pkg::MOD_Q);
        end
        if (i_cmd.mul_start) begin
            r_ph  <= '0;
            r_acc <= '0;
            if (i_cmd.mul_sel == dmcsr_pkg::MUL_MIX) begin
                r_a <= w1;
                r_b <= w2;
            end else begin
                r_a <= mid;
                r_b <= mid;
            end
        end else begin
            if (i_cmd.mul_part) begin
                r_pp    <= n_pp;
                r_pp_ph <= r_ph;
                r_ph    <= r_ph + 2'd1;
            end
            if (i_cmd.mul_fold) begin
                r_acc <= r_acc + pp_sh;
            end
        end
        if (i_cmd.out_load) begin
            r_word <= r_acc[95:32];
        end
    end
endmodule

// File: design/dmcsr_ctrl.sv
module dmcsr_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_in_op,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output dmcsr_pkg::t_cmd o_cmd,
    input  dmcsr_pkg::t_sts i_sts
);
    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_SEEK = 7'b0000010,
        S_MUL1 = 7'b0000100,
        S_FIN1 = 7'b0001000,
        S_SQ   = 7'b0010000,
        S_FIN2 = 7'b0100000,
        S_OUT  = 7'b1000000
    } t_state;

    t_state      r_state, n_state;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_oval, n_oval;
    logic        r_sq_go;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_oval;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_oval  = r_oval && !i_out_ready;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    if (i_in_op == dmcsr_pkg::OP_SEEK) begin
                        o_cmd.seek_clear = 1'b1;
                        n_cnt   = '0;
                        n_state = S_SEEK;
                    end else begin
                        o_cmd.mul_start = 1'b1;
                        o_cmd.mul_sel   = dmcsr_pkg::MUL_MIX;
                        n_state = S_MUL1;
                    end
                end
            end
            S_SEEK: begin
                o_cmd.seek_step = 1'b1;
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    n_state = S_IDLE;
                end
            end
            S_MUL1: begin
                o_cmd.mul_part = 1'b1;
                o_cmd.mul_fold = (r_cnt != 6'd0);
                n_cnt = r_cnt + 6'd1;
                if (i_sts.mul_last) begin
                    n_state = S_FIN1;
                end
            end
            S_FIN1: begin
                o_cmd.mul_fold = 1'b1;
                n_state = S_SQ;
            end
            S_SQ: begin
                if (r_sq_go) begin
                    o_cmd.mul_start = 1'b1;
                    o_cmd.mul_sel   = dmcsr_pkg::MUL_SQR;
                end else begin
                    o_cmd.mul_part = 1'b1;
                    o_cmd.mul_fold = (r_cnt != 6'd0);
                    n_cnt = r_cnt + 6'd1;
                    if (i_sts.mul_last) begin
                        n_state = S_FIN2;
                    end
                end
            end
            S_FIN2: begin
                o_cmd.mul_fold = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_oval || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.adv      = 1'b1;
                    n_oval  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        if (r_state == S_FIN1) begin
            o_cmd.mul_start = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_oval  <= 1'b0;
            r_sq_go <= 1'b0;
        end else begin
            r_state <= n_state;
            r_oval  <= n_oval;
            r_sq_go <= (r_state == S_FIN1);
            if ((r_state == S_MUL1 || r_state == S_SQ) && i_sts.mul_last) begin
                r_cnt <= '0;
            end else if (r_state == S_IDLE && i_in_valid) begin
                r_cnt <= '0;
            end else begin
                r_cnt <= n_cnt;
            end
        end
    end
endmodule
